[hw/rtl/rpac_pkg.sv]
// ----------------------------------------------------------------------------
// rpac_pkg: shared constants for the point rotation pipeline
// CORDIC arctangent table, gain constant and fixed internal widths.
// ----------------------------------------------------------------------------
package rpac_pkg;

  // Angle is handled left-aligned in units of 2^-32 turn
  localparam int ANGLE_ALIGN = 32;
  // Residual angle register width (signed)
  localparam int Z_WIDTH = 32;
  // Extra fraction bits carried through the rotation
  localparam int GUARD_BITS = 8;
  // Headroom for CORDIC growth and the quarter-turn swap
  localparam int GROWTH_BITS = 4;
  // Number of entries in the arctangent table
  localparam int ATAN_DEPTH = 32;

  // 1/K of the CORDIC rotation in Q0.32
  localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  localparam logic [31:0] ATAN_TURN [0:ATAN_DEPTH-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Quarter-turn codes (top two angle bits)
  localparam logic [1:0] QUARTER_0 = 2'd0;
  localparam logic [1:0] QUARTER_1 = 2'd1;
  localparam logic [1:0] QUARTER_2 = 2'd2;
  localparam logic [1:0] QUARTER_3 = 2'd3;

endpackage

[hw/rtl/rpac_cell.sv]
// ----------------------------------------------------------------------------
// rpac_cell: one CORDIC micro-rotation
// Rotates (x, y) by +/- atan(2^-STAGE) steered by the sign of the residual
// angle and hands the result to the next cell.
// ----------------------------------------------------------------------------
module rpac_cell #(
  parameter int W     = 44,
  parameter int STAGE = 0
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [W-1:0]                  x_in,
  input  logic signed [W-1:0]                  y_in,
  input  logic signed [rpac_pkg::Z_WIDTH-1:0]  z_in,
  output logic signed [W-1:0]                  x_out,
  output logic signed [W-1:0]                  y_out,
  output logic signed [rpac_pkg::Z_WIDTH-1:0]  z_out
);

  localparam logic signed [rpac_pkg::Z_WIDTH-1:0] ATAN =
    $signed(rpac_pkg::ATAN_TURN[STAGE]);

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic                rot_pos;

  // arithmetic shifts floor toward minus infinity
  assign xs      = x_in >>> STAGE;
  assign ys      = y_in >>> STAGE;
  assign rot_pos = ~z_in[rpac_pkg::Z_WIDTH-1];

  // micro-rotation register
  always_ff @(posedge clk) begin
    if (en) begin
      if (rot_pos) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

[hw/rtl/rpac_gain.sv]
// ----------------------------------------------------------------------------
// rpac_gain: gain removal, center add and saturation for one coordinate
// Four register stages: magnitude, partial products, round, add and clamp.
// ----------------------------------------------------------------------------
module rpac_gain #(
  parameter int W           = 44,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [W-1:0]           rot,
  input  logic signed [COORD_WIDTH-1:0] center,
  output logic signed [COORD_WIDTH-1:0] result
);

  // magnitude width, at least 33 so the high word is never empty
  localparam int MAGW = (W > 33) ? W : 33;
  localparam int HW   = MAGW - 32;
  localparam int TW   = MAGW + 1;
  localparam int RW   = TW - rpac_pkg::GUARD_BITS;
  localparam int SW   = ((COORD_WIDTH > RW + 1) ? COORD_WIDTH : RW + 1) + 1;
  localparam logic [TW-1:0] RND = TW'(64'd1 << (rpac_pkg::GUARD_BITS - 1));
  localparam logic signed [SW-1:0] SAT_HI =
    SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  // stage 1: sign and magnitude
  logic                          neg1;
  logic [MAGW-1:0]               mag1;
  logic signed [COORD_WIDTH-1:0] c1;
  logic [W-1:0]                  abs_w;

  assign abs_w = rot[W-1] ? W'(-rot) : W'(rot);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= rot[W-1];
      mag1 <= MAGW'(abs_w);
      c1   <= center;
    end
  end

  // stage 2: high and low word products with the gain constant
  logic                          neg2;
  logic [MAGW-1:0]               ph2;
  logic [31:0]                   pl2;
  logic signed [COORD_WIDTH-1:0] c2;
  logic [HW+31:0]                ph_full;
  logic [63:0]                   pl_full;

  assign ph_full = mag1[MAGW-1:32] * rpac_pkg::CORDIC_GAIN;
  assign pl_full = mag1[31:0] * rpac_pkg::CORDIC_GAIN;

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      ph2  <= MAGW'(ph_full);
      pl2  <= pl_full[63:32];
      c2   <= c1;
    end
  end

  // stage 3: sum, round half up on the magnitude, drop guard bits
  logic                          neg3;
  logic [RW-1:0]                 r3;
  logic signed [COORD_WIDTH-1:0] c3;
  logic [TW-1:0]                 t_sum;

  assign t_sum = TW'(ph2) + TW'(pl2) + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      neg3 <= neg2;
      r3   <= t_sum[TW-1:rpac_pkg::GUARD_BITS];
      c3   <= c2;
    end
  end

  // stage 4: restore sign against the center, clamp to coordinate range
  logic signed [SW-1:0] c_ext;
  logic signed [SW-1:0] r_ext;
  logic signed [SW-1:0] sum;

  assign c_ext = SW'(c3);
  assign r_ext = $signed({{(SW - RW){1'b0}}, r3});
  assign sum   = neg3 ? (c_ext - r_ext) : (c_ext + r_ext);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > SAT_HI) begin
        result <= SAT_HI[COORD_WIDTH-1:0];
      end else if (sum < SAT_LO) begin
        result <= SAT_LO[COORD_WIDTH-1:0];
      end else begin
        result <= sum[COORD_WIDTH-1:0];
      end
    end
  end

endmodule

[hw/rtl/rotate_point_about_center.sv]
// ----------------------------------------------------------------------------
// rotate_point_about_center: rotate a 2D point about a center
// Offset from center, exact quarter turn, CORDIC cell chain, gain removal,
// center add back with saturation. Fully pipelined.
//
//   channel  signals                                       direction
//   item     item_valid/item_ready, turn_angle, point_x,   in
//            point_y, center_x, center_y
//   result   result_valid/result_ready, rotated_x,         out
//            rotated_y
//
// One word accepted per cycle, one result per cycle, sustained while results are taken.
// Pipeline registers in order: offset, quarter turn, the register of each
// CORDIC cell, then the gain removal and clamping stages.
// The whole pipeline advances together; it stalls only while a result sits
// in the output register and result_ready is low.
// rst (synchronous) empties the pipeline; no data is cleared.
// ----------------------------------------------------------------------------
module rotate_point_about_center #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_WIDTH     = 32,
  parameter int ROTATION_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [ANGLE_WIDTH-1:0]        turn_angle,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y
);

  localparam int W   = COORD_WIDTH + rpac_pkg::GUARD_BITS + rpac_pkg::GROWTH_BITS;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int ZW  = rpac_pkg::Z_WIDTH;
  localparam int AW  = rpac_pkg::ANGLE_ALIGN;
  localparam int LAT = ROTATION_STAGES + 6;

  logic           en;
  logic [LAT-1:0] vld;

  // global advance: output register empty or being taken
  assign en           = ~vld[LAT-1] | result_ready;
  assign item_ready   = en & ~rst;
  assign result_valid = vld[LAT-1];

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item_valid};
    end
  end

  // stage 0: offsets from center, left-aligned angle
  logic signed [DW-1:0]          dx0;
  logic signed [DW-1:0]          dy0;
  logic [AW-1:0]                 ang0;
  logic signed [COORD_WIDTH-1:0] cx0;
  logic signed [COORD_WIDTH-1:0] cy0;

  always_ff @(posedge clk) begin
    if (en) begin
      dx0  <= DW'(point_x) - DW'(center_x);
      dy0  <= DW'(point_y) - DW'(center_y);
      ang0 <= AW'(turn_angle) << (AW - ANGLE_WIDTH);
      cx0  <= center_x;
      cy0  <= center_y;
    end
  end

  // stage 1: guard scaling and exact quarter turn
  logic signed [W-1:0]           dxs;
  logic signed [W-1:0]           dys;
  logic signed [W-1:0]           x1;
  logic signed [W-1:0]           y1;
  logic signed [W-1:0]           x1_next;
  logic signed [W-1:0]           y1_next;
  logic signed [ZW-1:0]          z1;
  logic signed [COORD_WIDTH-1:0] cx1;
  logic signed [COORD_WIDTH-1:0] cy1;

  assign dxs = W'(dx0) <<< rpac_pkg::GUARD_BITS;
  assign dys = W'(dy0) <<< rpac_pkg::GUARD_BITS;

  always_comb begin
    case (ang0[AW-1:AW-2])
      rpac_pkg::QUARTER_0: begin
        x1_next = dxs;
        y1_next = dys;
      end
      rpac_pkg::QUARTER_1: begin
        x1_next = -dys;
        y1_next = dxs;
      end
      rpac_pkg::QUARTER_2: begin
        x1_next = -dxs;
        y1_next = -dys;
      end
      rpac_pkg::QUARTER_3: begin
        x1_next = dys;
        y1_next = -dxs;
      end
      default: begin
        x1_next = dxs;
        y1_next = dys;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x1_next;
      y1  <= y1_next;
      z1  <= $signed(ZW'(ang0[AW-3:0]));
      cx1 <= cx0;
      cy1 <= cy0;
    end
  end

  // CORDIC cell chain with center delay line alongside
  logic signed [W-1:0]           xc [0:ROTATION_STAGES];
  logic signed [W-1:0]           yc [0:ROTATION_STAGES];
  logic signed [ZW-1:0]          zc [0:ROTATION_STAGES];
  logic signed [COORD_WIDTH-1:0] cxd [0:ROTATION_STAGES-1];
  logic signed [COORD_WIDTH-1:0] cyd [0:ROTATION_STAGES-1];

  assign xc[0] = x1;
  assign yc[0] = y1;
  assign zc[0] = z1;

  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    rpac_cell #(
      .W     (W),
      .STAGE (g)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (xc[g]),
      .y_in  (yc[g]),
      .z_in  (zc[g]),
      .x_out (xc[g+1]),
      .y_out (yc[g+1]),
      .z_out (zc[g+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        if (g == 0) begin
          cxd[g] <= cx1;
          cyd[g] <= cy1;
        end else begin
          cxd[g] <= cxd[(g == 0) ? 0 : g - 1];
          cyd[g] <= cyd[(g == 0) ? 0 : g - 1];
        end
      end
    end
  end

  // gain removal and center add back, one unit per coordinate
  rpac_gain #(
    .W           (W),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_gain_x (
    .clk    (clk),
    .en     (en),
    .rot    (xc[ROTATION_STAGES]),
    .center (cxd[ROTATION_STAGES-1]),
    .result (rotated_x)
  );

  rpac_gain #(
    .W           (W),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_gain_y (
    .clk    (clk),
    .en     (en),
    .rot    (yc[ROTATION_STAGES]),
    .center (cyd[ROTATION_STAGES-1]),
    .result (rotated_y)
  );

  // pipeline bookkeeping checks
  a_rst_empty : assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid line moved during stall");

  a_enter : assert property (@(posedge clk) disable iff (rst)
    en |=> vld[0] == $past(item_valid))
    else $error("accepted word not tracked");

  a_shift : assert property (@(posedge clk) disable iff (rst)
    en |=> vld[LAT-1:1] == $past(vld[LAT-2:0]))
    else $error("valid line lost or duplicated a word");

endmodule
